FILE: rtl/core/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    // Field widths
    localparam int HUE_W = 9;
    localparam int PCT_W = 7;
    localparam int CH_W  = 8;
    localparam int TRI_W = 6;
    localparam int SEC_W = 3;
    localparam int SV_W  = 14;
    localparam int NUM_W = 20;
    localparam int Y_W   = 28;
    localparam int Z_W   = 22;

    // Pipeline depth, input register to output register
    localparam int STAGES = 7;

    // Channel order
    localparam int CH_NUM   = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [HUE_W-1:0] hue_t;
    typedef logic [PCT_W-1:0] pct_t;
    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [TRI_W-1:0] tri_t;
    typedef logic [SEC_W-1:0] sector_t;
    typedef logic [SV_W-1:0]  sv_t;
    typedef logic [NUM_W-1:0] num_t;
    typedef logic [Y_W-1:0]   y_t;
    typedef logic [Z_W-1:0]   z_t;

    // Percent ceiling
    localparam pct_t PCT_MAX = 7'd100;

    // Scaling: every term is kept over 600000 = 100 * 100 * 60
    localparam logic [5:0]  SV_TO_NUM  = 6'd60;
    localparam logic [12:0] VAL_TO_NUM = 13'd6000;
    localparam num_t        NUM_DEN    = 20'd600000;
    localparam y_t          ROUND_HALF = 28'd300000;

    // Divide by 600000 as a shift by 6, then by 9375 through a reciprocal
    localparam int            DIV_SHIFT   = 6;
    localparam logic [13:0]   DIV_ODD     = 14'd9375;
    localparam int            RECIP_SHIFT = 32;
    localparam logic [18:0]   RECIP       = 19'd458129;
    localparam int            PROD_W      = Z_W + 19;

    // Hue sectors of 60 degrees
    localparam sector_t SEC_RY = 3'd0;
    localparam sector_t SEC_YG = 3'd1;
    localparam sector_t SEC_GC = 3'd2;
    localparam sector_t SEC_CB = 3'd3;
    localparam sector_t SEC_BM = 3'd4;
    localparam sector_t SEC_MR = 3'd5;

    // Sector of a hue; a full turn or more stays in the last sector
    function automatic sector_t hue_sector(hue_t hue);
        sector_t s;
        if (hue >= 9'd300)
            s = SEC_MR;
        else if (hue >= 9'd240)
            s = SEC_BM;
        else if (hue >= 9'd180)
            s = SEC_CB;
        else if (hue >= 9'd120)
            s = SEC_GC;
        else if (hue >= 9'd60)
            s = SEC_YG;
        else
            s = SEC_RY;
        return s;
    endfunction

    // Triangle weight 60 - |(hue mod 120) - 60|
    function automatic tri_t hue_tri(hue_t hue);
        hue_t h120;
        tri_t w;
        if (hue >= 9'd480)
            h120 = hue - 9'd480;
        else if (hue >= 9'd360)
            h120 = hue - 9'd360;
        else if (hue >= 9'd240)
            h120 = hue - 9'd240;
        else if (hue >= 9'd120)
            h120 = hue - 9'd120;
        else
            h120 = hue;
        if (h120 < 9'd60)
            w = h120[TRI_W-1:0];
        else
            w = 6'(9'd120 - h120);
        return w;
    endfunction

endpackage

FILE: rtl/core/hsv_pix_if.sv
interface hsv_pix_if;
    logic                valid;
    logic                ready;
    hsv2rgb_pkg::hue_t   hue;
    hsv2rgb_pkg::pct_t   saturation;
    hsv2rgb_pkg::pct_t   brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

FILE: rtl/core/rgb_pix_if.sv
interface rgb_pix_if;
    logic                valid;
    logic                ready;
    hsv2rgb_pkg::chan_t  red;
    hsv2rgb_pkg::chan_t  green;
    hsv2rgb_pkg::chan_t  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/core/hsv_to_rgb_converter.sv
// Channel | Dir | Payload                         | Handshake
// hsv     | in  | hue 9b, saturation 7b, bright 7b | valid/ready
// rgb     | out | red 8b, green 8b, blue 8b        | valid/ready
//
// One request per clock while the output is not stalled, through seven register
// stages; an accepted request moves through them in order to the output register.
// Stage 1 clamps and decodes the hue, later stages hold the multiplies and wide adds;
// the last three do the divide by 600000 (shift, reciprocal multiply, one-step correction).
// rst_n clears the stage valid bits only; payload registers are not reset.
// A stage advances when it is empty or the next stage advances, so bubbles
// close up and a stalled output never drops or repeats a request.
module hsv_to_rgb_converter (
    input  logic             clk,
    input  logic             rst_n,
    hsv_pix_if.sink          hsv,
    rgb_pix_if.source        rgb
);
    import hsv2rgb_pkg::*;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] en;

    // Stage 1: clamped percents, triangle weight, sector
    pct_t    sat_reg;
    pct_t    val1_reg;
    tri_t    tri1_reg;
    sector_t sec1_reg;
    // Stage 2: saturation times value
    sv_t     sv_reg;
    pct_t    val2_reg;
    tri_t    tri2_reg;
    sector_t sec2_reg;
    // Stage 3: chroma, intermediate term, value term
    num_t    c_reg;
    num_t    x_reg;
    num_t    mv_reg;
    sector_t sec3_reg;
    // Stages 4 to 6: per-channel numerator, shifted dividend, estimate
    num_t    num_reg [CH_NUM];
    z_t      z5_reg  [CH_NUM];
    z_t      z6_reg  [CH_NUM];
    chan_t   q6_reg  [CH_NUM];
    // Stage 7: output codes
    chan_t   code_reg [CH_NUM];

    pct_t    sat_clamp;
    pct_t    val_clamp;
    num_t    m_term;
    num_t    route [CH_NUM];
    num_t    num_next [CH_NUM];
    z_t      z_next [CH_NUM];
    chan_t   q_next [CH_NUM];
    z_t      rem [CH_NUM];
    chan_t   code_next [CH_NUM];
    logic [PROD_W-1:0] prod [CH_NUM];
    y_t      y [CH_NUM];
    logic [Z_W+13:0] back [CH_NUM];

    // Advance chain, from the output back to the input
    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || rgb.ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        for (int i = 0; i < STAGES; i++)
        begin
            if (i == 0)
                v_next[i] = en[i] ? hsv.valid : v_reg[i];
            else
                v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign hsv.ready = en[0];
    assign rgb.valid = v_reg[STAGES-1];
    assign rgb.red   = code_reg[CH_RED];
    assign rgb.green = code_reg[CH_GREEN];
    assign rgb.blue  = code_reg[CH_BLUE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // Saturate percents above hundred
    assign sat_clamp = (hsv.saturation > PCT_MAX) ? PCT_MAX : hsv.saturation;
    assign val_clamp = (hsv.brightness > PCT_MAX) ? PCT_MAX : hsv.brightness;

    // Route chroma and intermediate term by sector, then add value minus chroma
    always_comb
    begin
        m_term = mv_reg - c_reg;
        case (sec3_reg)
            SEC_RY:
            begin
                route[CH_RED] = c_reg;  route[CH_GREEN] = x_reg; route[CH_BLUE] = '0;
            end
            SEC_YG:
            begin
                route[CH_RED] = x_reg;  route[CH_GREEN] = c_reg; route[CH_BLUE] = '0;
            end
            SEC_GC:
            begin
                route[CH_RED] = '0;     route[CH_GREEN] = c_reg; route[CH_BLUE] = x_reg;
            end
            SEC_CB:
            begin
                route[CH_RED] = '0;     route[CH_GREEN] = x_reg; route[CH_BLUE] = c_reg;
            end
            SEC_BM:
            begin
                route[CH_RED] = x_reg;  route[CH_GREEN] = '0;    route[CH_BLUE] = c_reg;
            end
            default:
            begin
                route[CH_RED] = c_reg;  route[CH_GREEN] = '0;    route[CH_BLUE] = x_reg;
            end
        endcase
        for (int ch = 0; ch < CH_NUM; ch++)
        begin
            num_next[ch] = route[ch] + m_term;
        end
    end

    // Round to nearest: floor((255 * num + 300000) / 600000)
    always_comb
    begin
        for (int ch = 0; ch < CH_NUM; ch++)
        begin
            y[ch]      = {num_reg[ch], 8'd0} - Y_W'(num_reg[ch]) + ROUND_HALF;
            z_next[ch] = y[ch][Y_W-1:DIV_SHIFT];
            prod[ch]   = PROD_W'(z5_reg[ch]) * PROD_W'(RECIP);
            q_next[ch] = prod[ch][RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
            back[ch]   = (Z_W+14)'(q6_reg[ch]) * (Z_W+14)'(DIV_ODD);
            rem[ch]    = z6_reg[ch] - back[ch][Z_W-1:0];
            code_next[ch] = (rem[ch] >= Z_W'(DIV_ODD)) ? q6_reg[ch] + 8'd1 : q6_reg[ch];
        end
    end

    // Payload stages, loaded when their stage advances
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sat_reg  <= sat_clamp;
            val1_reg <= val_clamp;
            tri1_reg <= hue_tri(hsv.hue);
            sec1_reg <= hue_sector(hsv.hue);
        end
        if (en[1])
        begin
            sv_reg   <= SV_W'(sat_reg) * SV_W'(val1_reg);
            val2_reg <= val1_reg;
            tri2_reg <= tri1_reg;
            sec2_reg <= sec1_reg;
        end
        if (en[2])
        begin
            c_reg    <= NUM_W'(sv_reg) * NUM_W'(SV_TO_NUM);
            x_reg    <= NUM_W'(sv_reg) * NUM_W'(tri2_reg);
            mv_reg   <= NUM_W'(val2_reg) * NUM_W'(VAL_TO_NUM);
            sec3_reg <= sec2_reg;
        end
        for (int ch = 0; ch < CH_NUM; ch++)
        begin
            if (en[3])
                num_reg[ch] <= num_next[ch];
            if (en[4])
                z5_reg[ch] <= z_next[ch];
            if (en[5])
            begin
                z6_reg[ch] <= z5_reg[ch];
                q6_reg[ch] <= q_next[ch];
            end
            if (en[6])
                code_reg[ch] <= code_next[ch];
        end
    end

    // Sector code stays within the six sectors
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] |-> sec1_reg <= SEC_MR)
        else $error("sector code out of range");

    // Channel numerators never pass the common denominator
    a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] |-> (num_reg[CH_RED] <= NUM_DEN && num_reg[CH_GREEN] <= NUM_DEN
                      && num_reg[CH_BLUE] <= NUM_DEN))
        else $error("channel numerator above full scale");

    // Reciprocal estimate is short by at most one
    a_quot_fix: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[5] |-> (rem[CH_RED] < Z_W'(2 * DIV_ODD) && rem[CH_GREEN] < Z_W'(2 * DIV_ODD)
                      && rem[CH_BLUE] < Z_W'(2 * DIV_ODD)))
        else $error("quotient estimate off by more than one");

    // A blocked third stage keeps its request, its chroma and its intermediate term
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] && !en[2] |=> v_reg[2] && $stable(c_reg) && $stable(x_reg))
        else $error("stalled stage lost its request");

endmodule

FILE: verif/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb;

    import hsv2rgb_pkg::*;

    // Channel code is round(255 * num / 600000), halves rounded up
    localparam int unsigned FULL_CODE = 255;
    localparam int unsigned SCALE_DEN = 600000;
    localparam int unsigned SCALE_HALF = 300000;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_px_t;

    logic clk;
    logic rst_n;

    hsv_pix_if hsv_bus();
    rgb_pix_if rgb_bus();

    rgb_px_t pending_rgb[$];
    int      n_errors;
    bit      sender_idles;
    bit      sink_stalls;
    int      stall_left;

    hsv_to_rgb_converter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv_bus),
        .rgb   (rgb_bus)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Scale one channel numerator over 600000 to an 8-bit code
    function automatic chan_t chan_code(int unsigned num);
        return chan_t'((FULL_CODE * num + SCALE_HALF) / SCALE_DEN);
    endfunction

    // Expected RGB of one HSV pixel, exact over the common denominator
    function automatic rgb_px_t rgb_of_hsv(hue_t hue, pct_t sat_in, pct_t val_in);
        int unsigned sat;
        int unsigned val;
        int unsigned h_mod;
        int unsigned weight;
        int unsigned chroma;
        int unsigned mid;
        int unsigned base;
        int unsigned r_num;
        int unsigned g_num;
        int unsigned b_num;
        sector_t     sec;
        rgb_px_t     px;
        sat = 32'((sat_in > PCT_MAX) ? PCT_MAX : sat_in);
        val = 32'((val_in > PCT_MAX) ? PCT_MAX : val_in);
        h_mod = hue % 120;
        weight = (h_mod >= 60) ? (120 - h_mod) : h_mod;
        chroma = 60 * sat * val;
        mid = sat * val * weight;
        base = 6000 * val - chroma;
        // a full turn or more stays in the magenta-red sector
        sec = (hue < 360) ? sector_t'(hue / 60) : SEC_MR;
        case (sec)
            SEC_RY:
            begin
                r_num = chroma; g_num = mid; b_num = 0;
            end
            SEC_YG:
            begin
                r_num = mid; g_num = chroma; b_num = 0;
            end
            SEC_GC:
            begin
                r_num = 0; g_num = chroma; b_num = mid;
            end
            SEC_CB:
            begin
                r_num = 0; g_num = mid; b_num = chroma;
            end
            SEC_BM:
            begin
                r_num = mid; g_num = 0; b_num = chroma;
            end
            default:
            begin
                r_num = chroma; g_num = 0; b_num = mid;
            end
        endcase
        px.red   = chan_code(r_num + base);
        px.green = chan_code(g_num + base);
        px.blue  = chan_code(b_num + base);
        return px;
    endfunction

    // Send one pixel request; entered and left at a falling edge
    task automatic send_pixel(hue_t hue, pct_t sat, pct_t val);
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            hsv_bus.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        hsv_bus.valid      = 1'b1;
        hsv_bus.hue        = hue;
        hsv_bus.saturation = sat;
        hsv_bus.brightness = val;
        do
            @(posedge clk);
        while (!hsv_bus.ready);
        pending_rgb.push_back(rgb_of_hsv(hue, sat, val));
        @(negedge clk);
    endtask

    // Hold the input until every outstanding pixel has come out
    task automatic drain_pixels();
        hsv_bus.valid = 1'b0;
        while (pending_rgb.size() != 0)
            @(negedge clk);
    endtask

    // Sector boundaries, hues of a full turn and beyond
    task automatic test_sector_edges();
        send_pixel(9'd0, 7'd100, 7'd100);
        send_pixel(9'd59, 7'd100, 7'd100);
        send_pixel(9'd60, 7'd100, 7'd100);
        send_pixel(9'd119, 7'd100, 7'd100);
        send_pixel(9'd120, 7'd100, 7'd100);
        send_pixel(9'd179, 7'd100, 7'd100);
        send_pixel(9'd180, 7'd100, 7'd100);
        send_pixel(9'd239, 7'd100, 7'd100);
        send_pixel(9'd240, 7'd87, 7'd93);
        send_pixel(9'd299, 7'd87, 7'd93);
        send_pixel(9'd300, 7'd87, 7'd93);
        send_pixel(9'd359, 7'd87, 7'd93);
        send_pixel(9'd360, 7'd127, 7'd127);
        send_pixel(9'd419, 7'd100, 7'd100);
        send_pixel(9'd480, 7'd100, 7'd100);
        send_pixel(9'd511, 7'd127, 7'd127);
    endtask

    // Percent fields at zero, at the ceiling and above it
    task automatic test_percent_extremes();
        send_pixel(9'd200, 7'd0, 7'd0);
        send_pixel(9'd200, 7'd127, 7'd127);
        send_pixel(9'd200, 7'd101, 7'd100);
        send_pixel(9'd200, 7'd100, 7'd101);
        send_pixel(9'd45, 7'd64, 7'd1);
    endtask

    // Gray levels that land exactly halfway between two codes
    task automatic test_exact_halves();
        send_pixel(9'd10, 7'd0, 7'd10);
        send_pixel(9'd300, 7'd0, 7'd30);
        send_pixel(9'd511, 7'd0, 7'd90);
    endtask

    // Random pixels, mostly in the normal range, some over the full field widths
    task automatic test_random_mix(int count, bit idles);
        sender_idles = idles;
        sink_stalls  = idles;
        repeat (count)
        begin
            if ($urandom_range(0, 3) != 0)
                send_pixel(hue_t'($urandom_range(0, 359)), pct_t'($urandom_range(0, 100)),
                           pct_t'($urandom_range(0, 100)));
            else
                send_pixel(hue_t'($urandom), pct_t'($urandom), pct_t'($urandom));
        end
    endtask

    // Output ready: random stall bursts
    initial
    begin
        rgb_bus.ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (sink_stalls && $urandom_range(0, 7) == 0)
            begin
                rgb_bus.ready = 1'b0;
                stall_left = $urandom_range(0, 14);
            end
            else
                rgb_bus.ready = 1'b1;
        end
    end

    // Compare each result with the oldest expected pixel
    always @(posedge clk)
    begin
        rgb_px_t want;
        if (rst_n && rgb_bus.valid && rgb_bus.ready)
        begin
            if (pending_rgb.size() == 0)
            begin
                $error("result with none pending: red %0d green %0d blue %0d",
                       rgb_bus.red, rgb_bus.green, rgb_bus.blue);
                n_errors++;
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (rgb_bus.red !== want.red)
                begin
                    $error("red: expected %0d, got %0d", want.red, rgb_bus.red);
                    n_errors++;
                end
                if (rgb_bus.green !== want.green)
                begin
                    $error("green: expected %0d, got %0d", want.green, rgb_bus.green);
                    n_errors++;
                end
                if (rgb_bus.blue !== want.blue)
                begin
                    $error("blue: expected %0d, got %0d", want.blue, rgb_bus.blue);
                    n_errors++;
                end
            end
        end
    end

    // Hard stop
    initial
    begin
        #1000000;
        $display("hsv_to_rgb_converter_tb NOT OK");
        $finish;
    end

    initial
    begin
        n_errors           = 0;
        sender_idles       = 1'b1;
        sink_stalls        = 1'b1;
        rst_n              = 1'b0;
        hsv_bus.valid      = 1'b0;
        hsv_bus.hue        = '0;
        hsv_bus.saturation = '0;
        hsv_bus.brightness = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_sector_edges();
        test_percent_extremes();
        test_exact_halves();
        test_random_mix(400, 1'b1);
        test_random_mix(100, 1'b0);
        drain_pixels();
        test_random_mix(350, 1'b1);
        test_random_mix(150, 1'b0);

        // wait out the pipeline and catch any stray result
        drain_pixels();
        repeat (STAGES + 8) @(negedge clk);
        if (n_errors == 0 && pending_rgb.size() == 0)
            $display("hsv_to_rgb_converter_tb OK");
        else
            $display("hsv_to_rgb_converter_tb NOT OK");
        $finish;
    end

endmodule
